// ----- sv/bct_pkg.sv -----
`default_nettype none

package bct_pkg;

    localparam int MAX_BLOCKS       = 4096;
    localparam int BLOCKS_PER_PIECE = 16;
    localparam int PIECE_SLOTS      = MAX_BLOCKS / BLOCKS_PER_PIECE;
    localparam int BLOCK_W          = $clog2(MAX_BLOCKS);
    localparam int PIECE_W          = $clog2(PIECE_SLOTS);
    localparam int SLOT_W           = $clog2(BLOCKS_PER_PIECE);
    localparam int TOTAL_W          = 13;
    localparam int COV_W            = 5;
    localparam int CNT_W            = 8;
    localparam logic [CNT_W-1:0] DL_LIMIT = 8'd255;

    // Operation codes carried in the input tuser.
    typedef enum logic [2:0] {
        MODE_BLOCK_ADD,
        MODE_BLOCK_REM,
        MODE_DL_ADD,
        MODE_DL_REM,
        MODE_PIECE_ADD,
        MODE_LOAD_BITS,
        MODE_FIND_FREE,
        MODE_FIND_LEAST
    } mode_t;

    // One stored row holds everything known about one piece.
    typedef struct packed {
        logic                                        piece_done;
        logic [COV_W-1:0]                            cov;
        logic [BLOCKS_PER_PIECE-1:0][CNT_W-1:0]      cnt;
        logic [BLOCKS_PER_PIECE-1:0]                 done;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    // Operands of the shared per-block unit.
    typedef struct packed {
        mode_t              mode;
        logic               act;
        logic               done;
        logic [CNT_W-1:0]   cnt;
        logic               found;
        logic [CNT_W-1:0]   best;
        logic [COV_W-1:0]   cov;
        logic [TOTAL_W-1:0] total;
    } step_in_t;

    // Results of the shared per-block unit.
    typedef struct packed {
        logic               done;
        logic [CNT_W-1:0]   cnt;
        logic               found;
        logic [CNT_W-1:0]   best;
        logic               take;
        logic [COV_W-1:0]   cov;
        logic [TOTAL_W-1:0] total;
    } step_out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SCAN,
        ST_WB,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- sv/block_completion_tracker.sv -----
`default_nettype none

// Tracks which blocks of a download are done, grouped into pieces of sixteen
// blocks, one stored row per piece. After reset the block clears every row of its
// memory and takes no word meanwhile. Every valid request then passes through one
// memory read, one row load, sixteen passes of the shared per-block unit over the
// piece row, one write-back and one result stage before its result is ready; a
// new request is taken only once the tracker is back in idle. A request with an
// index at or beyond the block total changes nothing and goes straight to the
// result stage. The result stage waits while an earlier result has not been taken.
// One request is in work at a time; the result register lets the next request
// enter while a result still waits to be taken.
module block_completion_tracker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_tdata: block_index[11:0], piece_index[19:12], piece_bits[35:20], zeros.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,
    // s_tuser: mode[2:0].
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: found[0], found_block[12:1], min_downloaders[20:13],
    // piece_done[21], missing_in_piece[26:22], blocks_done[39:27],
    // bad_index[40], zeros.
    output logic [47:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import bct_pkg::*;

    state_t                  state_reg, state_next;
    logic [PIECE_W-1:0]      clr_reg, clr_next;
    logic [TOTAL_W-1:0]      cfg_total_reg;
    logic [TOTAL_W-1:0]      done_total_reg, done_total_next;
    mode_t                   mode_reg, mode_next;
    logic [SLOT_W-1:0]       sel_reg, sel_next;
    logic [PIECE_W-1:0]      piece_reg, piece_next;
    logic [BLOCKS_PER_PIECE-1:0] bits_reg, bits_next;
    logic                    bad_reg, bad_next;
    logic [SLOT_W-1:0]       j_reg, j_next;
    row_t                    row_reg, row_next;
    logic                    found_reg, found_next;
    logic [CNT_W-1:0]        best_reg, best_next;
    logic [SLOT_W-1:0]       fslot_reg, fslot_next;
    logic                    all_reg, all_next;
    logic                    m_valid_reg, m_valid_next;
    logic [47:0]             m_data_reg, m_data_next;

    logic [TOTAL_W-1:0]      t_eff;
    logic [PIECE_W:0]        piece_cnt;
    logic [TOTAL_W-1:0]      left;
    logic [COV_W-1:0]        n_size;
    logic                    in_piece;
    logic                    in_bad;
    mode_t                   in_mode;
    logic [BLOCK_W-1:0]      in_blk;
    logic [PIECE_W-1:0]      in_piece_idx;
    logic                    accept;
    logic                    out_free;
    logic [COV_W-1:0]        miss;
    logic                    ram_we;
    logic [PIECE_W-1:0]      ram_waddr;
    logic [ROW_W-1:0]        ram_wdata;
    logic [ROW_W-1:0]        ram_rdata;
    step_in_t                su_in;
    step_out_t               su_out;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {19'd0, cfg_total_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_total_reg <= TOTAL_W'(MAX_BLOCKS);
        end
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
        begin
            cfg_total_reg <= pwdata[TOTAL_W-1:0];
        end
    end

    // Effective total, piece count and size of the addressed piece.
    always_comb
    begin
        if (cfg_total_reg == '0)
        begin
            t_eff = TOTAL_W'(1);
        end
        else if (cfg_total_reg > TOTAL_W'(MAX_BLOCKS))
        begin
            t_eff = TOTAL_W'(MAX_BLOCKS);
        end
        else
        begin
            t_eff = cfg_total_reg;
        end
        piece_cnt = (PIECE_W + 1)'((t_eff + TOTAL_W'(BLOCKS_PER_PIECE - 1)) >> SLOT_W);
        left      = t_eff - TOTAL_W'({piece_reg, {SLOT_W{1'b0}}});
        n_size    = (left >= TOTAL_W'(BLOCKS_PER_PIECE)) ? COV_W'(BLOCKS_PER_PIECE)
                                                         : left[COV_W-1:0];
        in_piece  = {1'b0, j_reg} < n_size;
        miss      = (n_size > row_reg.cov) ? COV_W'(n_size - row_reg.cov) : '0;
    end

    // Input decode and range check.
    assign in_mode      = mode_t'(s_tuser);
    assign in_blk       = s_tdata[11:0];
    assign in_piece_idx = s_tdata[19:12];
    assign in_bad       = (in_mode <= MODE_DL_REM) ? ({1'b0, in_blk} >= t_eff)
                                                  : ({1'b0, in_piece_idx} >= piece_cnt);
    assign s_tready     = (state_reg == ST_IDLE);
    assign accept       = s_tvalid && s_tready;
    assign out_free     = !m_valid_reg || m_tready;

    // Shared per-block unit.
    always_comb
    begin
        su_in.mode  = mode_reg;
        su_in.done  = row_reg.done[j_reg];
        su_in.cnt   = row_reg.cnt[j_reg];
        su_in.found = found_reg;
        su_in.best  = best_reg;
        su_in.cov   = row_reg.cov;
        su_in.total = done_total_reg;
        unique case (mode_reg)
            MODE_BLOCK_ADD, MODE_BLOCK_REM, MODE_DL_ADD, MODE_DL_REM:
                su_in.act = (j_reg == sel_reg);
            MODE_LOAD_BITS:
                su_in.act = in_piece && bits_reg[j_reg];
            default:
                su_in.act = in_piece;
        endcase
    end

    bct_step u_step (
        .i (su_in),
        .o (su_out)
    );

    bct_ram #(
        .WIDTH (ROW_W),
        .DEPTH (PIECE_SLOTS)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (piece_reg),
        .rdata (ram_rdata)
    );

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        done_total_next = done_total_reg;
        mode_next       = mode_reg;
        sel_next        = sel_reg;
        piece_next      = piece_reg;
        bits_next       = bits_reg;
        bad_next        = bad_reg;
        j_next          = j_reg;
        row_next        = row_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        fslot_next      = fslot_reg;
        all_next        = all_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = piece_reg;
        ram_wdata       = row_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = PIECE_W'(clr_reg + 1'b1);
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = in_mode;
                    sel_next   = in_blk[SLOT_W-1:0];
                    piece_next = (in_mode <= MODE_DL_REM) ? in_blk[BLOCK_W-1:SLOT_W]
                                                          : in_piece_idx;
                    bits_next  = s_tdata[35:20];
                    bad_next   = in_bad;
                    state_next = in_bad ? ST_DONE : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                row_next   = row_t'(ram_rdata);
                j_next     = '0;
                found_next = 1'b0;
                best_next  = DL_LIMIT;
                fslot_next = '0;
                all_next   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                row_next.done[j_reg] = su_out.done;
                row_next.cnt[j_reg]  = su_out.cnt;
                row_next.cov         = su_out.cov;
                done_total_next      = su_out.total;
                found_next           = su_out.found;
                best_next            = su_out.best;
                if (su_out.take)
                begin
                    fslot_next = j_reg;
                end
                if (in_piece && !bits_reg[j_reg])
                begin
                    all_next = 1'b0;
                end
                j_next = SLOT_W'(j_reg + 1'b1);
                if (&j_reg)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (mode_reg == MODE_PIECE_ADD || (mode_reg == MODE_LOAD_BITS && all_reg))
                begin
                    row_next.piece_done = 1'b1;
                end
                ram_we    = 1'b1;
                ram_wdata = row_next;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[39:27] = done_total_reg;
                    if (bad_reg)
                    begin
                        m_data_next[40] = 1'b1;
                    end
                    else
                    begin
                        m_data_next[0]     = found_reg;
                        m_data_next[12:1]  = found_reg ? {piece_reg, fslot_reg} : '0;
                        m_data_next[20:13] = (mode_reg == MODE_FIND_LEAST && found_reg)
                                             ? best_reg : '0;
                        m_data_next[21]    = row_reg.piece_done;
                        m_data_next[26:22] = miss;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            done_total_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            done_total_reg <= done_total_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        sel_reg    <= sel_next;
        piece_reg  <= piece_next;
        bits_reg   <= bits_next;
        bad_reg    <= bad_next;
        j_reg      <= j_next;
        row_reg    <= row_next;
        found_reg  <= found_next;
        best_reg   <= best_next;
        fslot_reg  <= fslot_next;
        all_reg    <= all_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The clearing pass covers every row before requests are taken.
    a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && state_next != ST_CLEAR) |-> (&clr_reg))
        else $error("clearing pass ended early");

    // The done count never exceeds the number of blocks.
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_total_reg <= TOTAL_W'(MAX_BLOCKS))
        else $error("done count out of range");

    // At write-back a piece never has more covered blocks than a full piece holds.
    a_cov_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) |-> (row_reg.cov <= COV_W'(BLOCKS_PER_PIECE)))
        else $error("covered count out of range");

    // Write-back is always followed by the result stage.
    a_wb_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) |=> (state_reg == ST_DONE))
        else $error("write-back not followed by result");

endmodule

`default_nettype wire

// ----- sv/bct_ram.sv -----
`default_nettype none

module bct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/bct_step.sv -----
`default_nettype none

module bct_step (
    input  wire bct_pkg::step_in_t  i,
    output bct_pkg::step_out_t      o
);

    import bct_pkg::*;

    // Applies the current operation to one block of the piece row.
    always_comb
    begin
        o.done  = i.done;
        o.cnt   = i.cnt;
        o.found = i.found;
        o.best  = i.best;
        o.take  = 1'b0;
        o.cov   = i.cov;
        o.total = i.total;
        if (i.act)
        begin
            unique case (i.mode)
                MODE_BLOCK_ADD, MODE_PIECE_ADD, MODE_LOAD_BITS:
                begin
                    if (!i.done)
                    begin
                        o.total = TOTAL_W'(i.total + 1'b1);
                        if (i.cnt == '0)
                        begin
                            o.cov = COV_W'(i.cov + 1'b1);
                        end
                        o.done = 1'b1;
                    end
                end
                MODE_BLOCK_REM:
                begin
                    if (i.done)
                    begin
                        if (i.total != '0)
                        begin
                            o.total = TOTAL_W'(i.total - 1'b1);
                        end
                        if (i.cnt == '0 && i.cov != '0)
                        begin
                            o.cov = COV_W'(i.cov - 1'b1);
                        end
                        o.done = 1'b0;
                    end
                end
                MODE_DL_ADD:
                begin
                    if (i.cnt == '0 && !i.done)
                    begin
                        o.cov = COV_W'(i.cov + 1'b1);
                    end
                    if (i.cnt != DL_LIMIT)
                    begin
                        o.cnt = CNT_W'(i.cnt + 1'b1);
                    end
                end
                MODE_DL_REM:
                begin
                    if (i.cnt != '0)
                    begin
                        o.cnt = CNT_W'(i.cnt - 1'b1);
                        if (i.cnt == CNT_W'(1) && !i.done && i.cov != '0)
                        begin
                            o.cov = COV_W'(i.cov - 1'b1);
                        end
                    end
                end
                MODE_FIND_FREE:
                begin
                    if (!i.found && !i.done && i.cnt == '0)
                    begin
                        o.found = 1'b1;
                        o.take  = 1'b1;
                    end
                end
                MODE_FIND_LEAST:
                begin
                    if (!i.done && (!i.found || i.cnt < i.best))
                    begin
                        o.best  = i.cnt;
                        o.found = 1'b1;
                        o.take  = 1'b1;
                    end
                end
                default:
                begin
                    o.take = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- bench/block_completion_tracker_tb.sv -----
`default_nettype none

module block_completion_tracker_tb;
    import bct_pkg::*;

    // Result of one request, in the order of the m_tdata fields.
    typedef struct packed {
        logic                bad;
        logic [12:0]         done_cnt;
        logic [4:0]          missing;
        logic                pdone;
        logic [7:0]          min_dl;
        logic [11:0]         fblock;
        logic                found;
    } tracker_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    block_completion_tracker dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    localparam logic [2:0] REG_TOTAL = 3'd0;
    localparam int CYCLE_LIMIT = 600000;

    // Tracker state as the bench expects it.
    logic        exp_done [MAX_BLOCKS];
    logic [7:0]  exp_cnt [MAX_BLOCKS];
    logic        exp_pdone [PIECE_SLOTS];
    logic [7:0]  exp_cov [PIECE_SLOTS];
    int          exp_total;
    int          total_reg;

    tracker_result_t pending_results[$];
    int  errors;
    int  cycles;
    int  sent;
    int  checked;
    int  stall_left;
    bit  quiet;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int eff_total();
        int t;
        t = total_reg;
        if (t < 1) t = 1;
        if (t > MAX_BLOCKS) t = MAX_BLOCKS;
        return t;
    endfunction

    function automatic int piece_len(int p);
        int left;
        left = eff_total() - p * BLOCKS_PER_PIECE;
        if (left < 0) left = 0;
        return left < BLOCKS_PER_PIECE ? left : BLOCKS_PER_PIECE;
    endfunction

    task automatic cover_up(int b);
        if (exp_cov[b / BLOCKS_PER_PIECE] < 255) exp_cov[b / BLOCKS_PER_PIECE]++;
    endtask

    task automatic cover_down(int b);
        if (exp_cov[b / BLOCKS_PER_PIECE] > 0) exp_cov[b / BLOCKS_PER_PIECE]--;
    endtask

    task automatic set_block_done(int b);
        if (!exp_done[b])
        begin
            exp_total++;
            if (exp_cnt[b] == 0) cover_up(b);
            exp_done[b] = 1'b1;
        end
    endtask

    task automatic set_piece_done(int p);
        for (int j = 0; j < piece_len(p); j++) set_block_done(p * BLOCKS_PER_PIECE + j);
        exp_pdone[p] = 1'b1;
    endtask

    // Applies one request to the expected state and returns its result.
    task automatic track_request(input mode_t m, input int blk, input int pc,
                                 input logic [15:0] bits, output tracker_result_t r);
        int p;
        int n;
        int best;
        int b;
        bit all;
        r = '0;
        if (m <= MODE_DL_REM)
        begin
            if (blk >= eff_total())
            begin
                r.bad = 1'b1;
                r.done_cnt = exp_total[12:0];
                return;
            end
            p = blk / BLOCKS_PER_PIECE;
            case (m)
                MODE_BLOCK_ADD: set_block_done(blk);
                MODE_BLOCK_REM:
                    if (exp_done[blk])
                    begin
                        if (exp_total > 0) exp_total--;
                        if (exp_cnt[blk] == 0) cover_down(blk);
                        exp_done[blk] = 1'b0;
                    end
                MODE_DL_ADD:
                begin
                    if (exp_cnt[blk] == 0 && !exp_done[blk]) cover_up(blk);
                    if (exp_cnt[blk] < 255) exp_cnt[blk]++;
                end
                default:
                    if (exp_cnt[blk] > 0)
                    begin
                        exp_cnt[blk]--;
                        if (exp_cnt[blk] == 0 && !exp_done[blk]) cover_down(blk);
                    end
            endcase
        end
        else
        begin
            if (pc >= (eff_total() + BLOCKS_PER_PIECE - 1) / BLOCKS_PER_PIECE)
            begin
                r.bad = 1'b1;
                r.done_cnt = exp_total[12:0];
                return;
            end
            p = pc;
            n = piece_len(p);
            case (m)
                MODE_PIECE_ADD: set_piece_done(p);
                MODE_LOAD_BITS:
                begin
                    all = 1'b1;
                    for (int j = 0; j < n; j++)
                        if (bits[j]) set_block_done(p * BLOCKS_PER_PIECE + j);
                        else all = 1'b0;
                    if (all) set_piece_done(p);
                end
                MODE_FIND_FREE:
                    for (int j = 0; j < n; j++)
                    begin
                        b = p * BLOCKS_PER_PIECE + j;
                        if (!r.found && !exp_done[b] && exp_cnt[b] == 0)
                        begin
                            r.found = 1'b1;
                            r.fblock = b[11:0];
                        end
                    end
                default:
                begin
                    best = 255;
                    for (int j = 0; j < n; j++)
                    begin
                        b = p * BLOCKS_PER_PIECE + j;
                        if (!exp_done[b] && (!r.found || exp_cnt[b] < best))
                        begin
                            best = exp_cnt[b];
                            r.fblock = b[11:0];
                            r.found = 1'b1;
                        end
                    end
                    if (r.found) r.min_dl = best[7:0];
                end
            endcase
        end
        n = piece_len(p);
        r.pdone = exp_pdone[p];
        r.missing = (n > exp_cov[p]) ? 5'(n - exp_cov[p]) : 5'd0;
        r.done_cnt = exp_total[12:0];
    endtask

    // Sometimes drops valid for a random gap, unless idling is switched off.
    task automatic maybe_idle();
        if (!quiet && $urandom_range(3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(negedge clk);
        end
    endtask

    // Sends one word and records its expected result when it is accepted.
    // The valid line stays up until the next gap or the next drain.
    task automatic send_request(input mode_t m, input int blk, input int pc,
                                input logic [15:0] bits);
        tracker_result_t r;
        maybe_idle();
        s_tuser  <= m;
        s_tdata  <= {4'b0, bits, pc[7:0], blk[11:0]};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        track_request(m, blk, pc, bits, r);
        pending_results.push_back(r);
        sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_total(input int value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= REG_TOTAL; pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        total_reg = value & 32'h1FFF;
    endtask

    // Block index is usually inside the block range in use.
    function automatic int pick_block();
        if ($urandom_range(15) == 0) return $urandom_range(4095);
        return $urandom_range(eff_total() - 1);
    endfunction

    function automatic int pick_piece();
        int pieces;
        pieces = (eff_total() + BLOCKS_PER_PIECE - 1) / BLOCKS_PER_PIECE;
        if ($urandom_range(15) == 0) return $urandom_range(255);
        if ($urandom_range(1) == 0) return pieces - 1;
        return $urandom_range(pieces - 1);
    endfunction

    task automatic random_request();
        mode_t m;
        int blk;
        m = mode_t'($urandom_range(7));
        // Focus downloaders on few blocks so counts grow large.
        blk = ($urandom_range(7) == 0) ? $urandom_range(3) : pick_block();
        send_request(m, blk, pick_piece(), 16'($urandom));
    endtask

    task automatic test_directed_default();
        send_request(MODE_FIND_FREE, 0, 0, 16'h0);
        send_request(MODE_FIND_LEAST, 0, 255, 16'h0);
        send_request(MODE_BLOCK_ADD, 4095, 0, 16'h0);
        send_request(MODE_BLOCK_ADD, 0, 0, 16'h0);
        send_request(MODE_BLOCK_REM, 0, 0, 16'h0);
        send_request(MODE_BLOCK_REM, 1, 0, 16'h0);
        send_request(MODE_DL_REM, 2, 0, 16'h0);
        send_request(MODE_DL_ADD, 2, 0, 16'h0);
        send_request(MODE_FIND_FREE, 0, 0, 16'h0);
        send_request(MODE_LOAD_BITS, 0, 1, 16'hFFFE);
        send_request(MODE_LOAD_BITS, 0, 1, 16'hFFFF);
        send_request(MODE_BLOCK_REM, 16, 0, 16'h0);
        send_request(MODE_PIECE_ADD, 0, 2, 16'h0);
        send_request(MODE_FIND_LEAST, 0, 2, 16'h0);
        send_request(MODE_FIND_LEAST, 0, 0, 16'h0);
    endtask

    // Downloader count climbs past its ceiling, then gets more removals than it holds.
    task automatic test_downloader_limits();
        for (int i = 0; i < 260; i++) send_request(MODE_DL_ADD, 48, 0, 16'h0);
        send_request(MODE_FIND_LEAST, 0, 3, 16'h0);
        for (int i = 0; i < 258; i++) send_request(MODE_DL_REM, 48, 0, 16'h0);
    endtask

    // A short last piece, then a shrink that strands covered blocks.
    task automatic test_short_total();
        write_total(21);
        send_request(MODE_LOAD_BITS, 0, 1, 16'hFFFF);
        send_request(MODE_BLOCK_ADD, 21, 0, 16'h0);
        send_request(MODE_FIND_FREE, 0, 2, 16'h0);
        for (int i = 0; i < 300; i++) random_request();
        wait_drained();
        write_total(17);
        send_request(MODE_FIND_FREE, 0, 1, 16'h0);
        for (int i = 0; i < 200; i++) random_request();
        wait_drained();
        write_total(0);
        send_request(MODE_BLOCK_ADD, 0, 0, 16'h0);
        send_request(MODE_FIND_LEAST, 0, 0, 16'h0);
        for (int i = 0; i < 60; i++) random_request();
        wait_drained();
    endtask

    task automatic test_random_sizes();
        write_total(8191);
        for (int i = 0; i < 200; i++) random_request();
        wait_drained();
        write_total($urandom_range(400, 2));
        for (int i = 0; i < 200; i++) random_request();
        wait_drained();
        write_total(4096);
        quiet = 1'b1;
        for (int i = 0; i < 250; i++) random_request();
    endtask

    // Receiver side: stalls of m_tready come in random bursts.
    always @(negedge clk)
    begin
        if (quiet)
        begin
            stall_left <= 0;
            m_tready   <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if ($urandom_range(7) == 0)
        begin
            stall_left <= $urandom_range(14);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        tracker_result_t got;
        tracker_result_t want;
        cycles <= cycles + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[40:0];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors <= errors + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                checked <= checked + 1;
                if (got !== want || m_tdata[47:41] !== 7'd0)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, m_tdata);
                    errors <= errors + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0; rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        errors = 0; cycles = 0; sent = 0; checked = 0; quiet = 1'b0;
        total_reg = 4096; exp_total = 0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin exp_done[i] = 0; exp_cnt[i] = 0; end
        for (int i = 0; i < PIECE_SLOTS; i++) begin exp_pdone[i] = 0; exp_cov[i] = 0; end
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        test_directed_default();
        test_downloader_limits();
        wait_drained();
        test_short_total();
        test_random_sizes();
        wait_drained();
        $display("Sent %0d requests over several block totals; %0d results checked.",
                 sent, checked);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ----- block_completion_tracker.f -----
sv/bct_pkg.sv
sv/bct_ram.sv
sv/bct_step.sv
sv/block_completion_tracker.sv
bench/block_completion_tracker_tb.sv
